FILE: rtl/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types, widths, register codes and reset values of the
// rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

    // Fixed field widths
    localparam int SLOT_COUNT = 4;      // register slots, independent of thread count
    localparam int PERIOD_W   = 16;
    localparam int EXEC_W     = 8;
    localparam int TOTAL_W    = 32;
    localparam int MASK_W     = 4;
    localparam int THREAD_W   = 2;

    // Default build parameters
    localparam int NUM_THREADS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    // APB port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    // Register index codes
    localparam logic [REG_W-1:0] REG_PERIOD_0 = 3'd0;
    localparam logic [REG_W-1:0] REG_PERIOD_1 = 3'd1;
    localparam logic [REG_W-1:0] REG_PERIOD_2 = 3'd2;
    localparam logic [REG_W-1:0] REG_PERIOD_3 = 3'd3;
    localparam logic [REG_W-1:0] REG_EXEC_0   = 3'd4;
    localparam logic [REG_W-1:0] REG_EXEC_1   = 3'd5;
    localparam logic [REG_W-1:0] REG_EXEC_2   = 3'd6;
    localparam logic [REG_W-1:0] REG_EXEC_3   = 3'd7;

    // Reset values
    localparam logic [SLOT_COUNT-1:0][PERIOD_W-1:0] PERIOD_RST =
        {16'd24, 16'd12, 16'd6, 16'd3};
    localparam logic [SLOT_COUNT-1:0][EXEC_W-1:0] EXEC_RST =
        {8'd4, 8'd2, 8'd2, 8'd1};

    localparam logic [EXEC_W-1:0]  PROG_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration seen by the scheduler core
    typedef struct packed {
        logic [SLOT_COUNT-1:0][PERIOD_W-1:0] period;
        logic [SLOT_COUNT-1:0][EXEC_W-1:0]   exec_size;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic                served_valid;
        logic [THREAD_W-1:0] served_thread;
        logic                task_done;
        logic [MASK_W-1:0]   released_mask;
        logic [MASK_W-1:0]   pending_mask;
        logic [MASK_W-1:0]   overflow_mask;
        logic [TOTAL_W-1:0]  released_total;
        logic [TOTAL_W-1:0]  completed_total;
    } t_result;

endpackage

FILE: rtl/rmts_tick_if.sv
// ----------------------------------------------------------------------------
// rmts_tick_if
// Tick channel: valid/ready handshake with a one-bit tick payload.
// ----------------------------------------------------------------------------
interface rmts_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

FILE: rtl/rmts_result_if.sv
// ----------------------------------------------------------------------------
// rmts_result_if
// Result channel: valid/ready handshake with scheduler status payload.
// ----------------------------------------------------------------------------
interface rmts_result_if;
    logic        valid;
    logic        ready;
    logic        served_valid;
    logic [1:0]  served_thread;
    logic        task_done;
    logic [3:0]  released_mask;
    logic [3:0]  pending_mask;
    logic [3:0]  overflow_mask;
    logic [31:0] released_total;
    logic [31:0] completed_total;

    modport source (output valid, output served_valid, output served_thread,
                    output task_done, output released_mask, output pending_mask,
                    output overflow_mask, output released_total,
                    output completed_total, input ready);
    modport sink   (input valid, input served_valid, input served_thread,
                    input task_done, input released_mask, input pending_mask,
                    input overflow_mask, input released_total,
                    input completed_total, output ready);
endinterface

FILE: rtl/rmts_apb_regs.sv
// ----------------------------------------------------------------------------
// rmts_apb_regs
// APB register file holding thread periods and job execution sizes.
// ----------------------------------------------------------------------------
module rmts_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmts_pkg::PADDR_W-1:0] paddr,
    input  logic [rmts_pkg::PDATA_W-1:0] pwdata,
    output logic [rmts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output rmts_pkg::t_cfg               o_cfg
);
    import rmts_pkg::*;

    logic [SLOT_COUNT-1:0][PERIOD_W-1:0] r_period;
    logic [SLOT_COUNT-1:0][EXEC_W-1:0]   r_exec;
    logic [REG_W-1:0]                    reg_idx;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_exec   <= EXEC_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PERIOD_0: r_period[0] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD_1: r_period[1] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD_2: r_period[2] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD_3: r_period[3] <= pwdata[PERIOD_W-1:0];
                REG_EXEC_0:   r_exec[0]   <= pwdata[EXEC_W-1:0];
                REG_EXEC_1:   r_exec[1]   <= pwdata[EXEC_W-1:0];
                REG_EXEC_2:   r_exec[2]   <= pwdata[EXEC_W-1:0];
                REG_EXEC_3:   r_exec[3]   <= pwdata[EXEC_W-1:0];
                default:      r_exec[3]   <= r_exec[3];
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_PERIOD_0: prdata = PDATA_W'(r_period[0]);
            REG_PERIOD_1: prdata = PDATA_W'(r_period[1]);
            REG_PERIOD_2: prdata = PDATA_W'(r_period[2]);
            REG_PERIOD_3: prdata = PDATA_W'(r_period[3]);
            REG_EXEC_0:   prdata = PDATA_W'(r_exec[0]);
            REG_EXEC_1:   prdata = PDATA_W'(r_exec[1]);
            REG_EXEC_2:   prdata = PDATA_W'(r_exec[2]);
            REG_EXEC_3:   prdata = PDATA_W'(r_exec[3]);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.period    = r_period;
    assign o_cfg.exec_size = r_exec;

endmodule

FILE: rtl/rmts_sched_core.sv
// ----------------------------------------------------------------------------
// rmts_sched_core
// Per-thread release counters, pending counts, head job progress and totals.
// One tick is applied per step; the result is produced combinationally.
// ----------------------------------------------------------------------------
module rmts_sched_core #(
    parameter int NUM_THREADS = rmts_pkg::NUM_THREADS_DEF,
    parameter int QUEUE_DEPTH = rmts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rmts_pkg::t_cfg    i_cfg,
    output rmts_pkg::t_result o_res
);
    import rmts_pkg::*;

    localparam int PEND_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RCNT_W = $clog2(NUM_THREADS + 1);
    localparam logic [PEND_W-1:0] PEND_FULL = PEND_W'(QUEUE_DEPTH);

    logic [PERIOD_W-1:0] r_phase [NUM_THREADS];
    logic [PEND_W-1:0]   r_pend  [NUM_THREADS];
    logic [EXEC_W-1:0]   r_prog  [NUM_THREADS];
    logic [TOTAL_W-1:0]  r_released;
    logic [TOTAL_W-1:0]  r_completed;

    logic [PERIOD_W-1:0] n_phase [NUM_THREADS];
    logic [PEND_W-1:0]   n_pend  [NUM_THREADS];
    logic [EXEC_W-1:0]   n_prog  [NUM_THREADS];
    logic [TOTAL_W-1:0]  n_released;
    logic [TOTAL_W-1:0]  n_completed;

    logic [PEND_W-1:0]   pend_rel [NUM_THREADS];
    logic [EXEC_W-1:0]   prog_inc [NUM_THREADS];
    logic [MASK_W-1:0]   rel_mask, pend_mask, ovf_mask;
    logic [RCNT_W-1:0]   rel_cnt;
    logic                found, done;
    logic [THREAD_W-1:0] sel;
    logic [TOTAL_W:0]    rel_sum;

    // Releases, priority service and counter updates
    always_comb begin
        rel_mask  = '0;
        pend_mask = '0;
        ovf_mask  = '0;
        rel_cnt   = '0;
        found     = 1'b0;
        done      = 1'b0;
        sel       = '0;
        for (int i = 0; i < NUM_THREADS; i++) begin
            if (r_phase[i] >= i_cfg.period[i]) begin
                n_phase[i] = PERIOD_W'(1);
                if (r_pend[i] >= PEND_FULL) begin
                    ovf_mask[i] = 1'b1;
                end else begin
                    rel_mask[i] = 1'b1;
                end
            end else begin
                n_phase[i] = r_phase[i] + PERIOD_W'(1);
            end
            pend_rel[i]  = r_pend[i] + PEND_W'(rel_mask[i]);
            pend_mask[i] = (pend_rel[i] != '0);
            rel_cnt      = rel_cnt + RCNT_W'(rel_mask[i]);
            prog_inc[i]  = (r_prog[i] == PROG_MAX) ? r_prog[i] : r_prog[i] + EXEC_W'(1);
            n_pend[i]    = pend_rel[i];
            n_prog[i]    = r_prog[i];
            // lowest-numbered thread with work gets one unit
            if (pend_mask[i] && !found) begin
                found = 1'b1;
                sel   = THREAD_W'(i);
                if (prog_inc[i] >= i_cfg.exec_size[i]) begin
                    done      = 1'b1;
                    n_prog[i] = '0;
                    n_pend[i] = pend_rel[i] - PEND_W'(1);
                end else begin
                    n_prog[i] = prog_inc[i];
                end
            end
        end
        rel_sum     = {1'b0, r_released} + (TOTAL_W + 1)'(rel_cnt);
        n_released  = rel_sum[TOTAL_W] ? TOTAL_MAX : rel_sum[TOTAL_W-1:0];
        n_completed = (done && r_completed != TOTAL_MAX) ?
                      r_completed + TOTAL_W'(1) : r_completed;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_phase[i] <= '0;
                r_pend[i]  <= '0;
                r_prog[i]  <= '0;
            end
            r_released  <= '0;
            r_completed <= '0;
        end else if (i_step) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                r_phase[i] <= n_phase[i];
                r_pend[i]  <= n_pend[i];
                r_prog[i]  <= n_prog[i];
            end
            r_released  <= n_released;
            r_completed <= n_completed;
        end
    end

    assign o_res.served_valid    = found;
    assign o_res.served_thread   = sel;
    assign o_res.task_done       = done;
    assign o_res.released_mask   = rel_mask;
    assign o_res.pending_mask    = pend_mask;
    assign o_res.overflow_mask   = ovf_mask;
    assign o_res.released_total  = n_released;
    assign o_res.completed_total = n_completed;

    // Checks
    a_done_needs_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.task_done |-> o_res.served_valid)
        else $error("job completed without service");

    a_rel_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.released_mask & o_res.overflow_mask) == '0)
        else $error("thread both released and overflowed");

    a_serve_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.served_valid |-> o_res.pending_mask[o_res.served_thread])
        else $error("served thread had no pending work");

    a_completed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_completed >= $past(r_completed))
        else $error("completed total went backward");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[0] <= PEND_FULL)
        else $error("pending count beyond queue depth");

endmodule

FILE: rtl/rate_monotonic_tick_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler
// Rate-monotonic scheduler for periodic threads driven by a tick stream,
// with APB-programmable periods and execution sizes.
//
//   Channel   Dir  Handshake        Payload
//   i_tick    in   valid/ready      tick
//   o_res     out  valid/ready      service, masks, totals
//   APB       in   psel/penable     period_0..3, exec_size_0..3 at 4*i
//
// One tick is accepted every cycle while the result is not stalled. A tick
// passes an input register and the scheduler update, and lands in the result
// register. A tick of 0 is consumed without a result. Synchronous active-low
// reset restores register defaults and clears all counters. A stalled result
// holds the result register; the input stage still accepts one more tick.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler #(
    parameter int NUM_THREADS = rmts_pkg::NUM_THREADS_DEF,
    parameter int QUEUE_DEPTH = rmts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rmts_tick_if.sink                    i_tick,
    rmts_result_if.source                o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rmts_pkg::PADDR_W-1:0] paddr,
    input  logic [rmts_pkg::PDATA_W-1:0] pwdata,
    output logic [rmts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import rmts_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result r_out;
    logic    r_out_valid;
    logic    r_s1_valid;
    logic    r_s1_tick;
    logic    s1_adv;
    logic    step;

    rmts_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rmts_sched_core #(
        .NUM_THREADS (NUM_THREADS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    // Stage advance: a zero tick never needs the result register
    assign s1_adv       = r_s1_valid & (~r_s1_tick | ~r_out_valid | o_res.ready);
    assign step         = s1_adv & r_s1_tick;
    assign i_tick.ready = ~r_s1_valid | s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_s1_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.ready && i_tick.valid) begin
            r_s1_tick <= i_tick.tick;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.served_valid    = r_out.served_valid;
    assign o_res.served_thread   = r_out.served_thread;
    assign o_res.task_done       = r_out.task_done;
    assign o_res.released_mask   = r_out.released_mask;
    assign o_res.pending_mask    = r_out.pending_mask;
    assign o_res.overflow_mask   = r_out.overflow_mask;
    assign o_res.released_total  = r_out.released_total;
    assign o_res.completed_total = r_out.completed_total;

endmodule
